// File: hdl/repeated_frame_bit_validator_macros.svh
// ----------------------------------------------------------------------------
// Repeated frame bit validator assertion macros
// Clocked assertion helpers shared by the validator RTL.
// ----------------------------------------------------------------------------
`ifndef REPEATED_FRAME_BIT_VALIDATOR_MACROS_SVH
`define REPEATED_FRAME_BIT_VALIDATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RFBV_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rfbv assertion failed");
`define RFBV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rfbv assertion failed");
`else
`define RFBV_ASSERT(lbl, prop)
`define RFBV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/rfbv_pkg.sv
// ----------------------------------------------------------------------------
// Repeated frame bit validator package
// Sizes of the bit window, the message and the stream words.
// ----------------------------------------------------------------------------
package rfbv_pkg;

	localparam int MSG_BITS     = 56;
	localparam int WIN_BITS     = 2 * MSG_BITS;
	localparam int OUT_MSG_BITS = 56;

	localparam int IN_FIELD_BITS  = 1;
	localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 3 + OUT_MSG_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

	typedef logic [MSG_BITS-1:0]       msg_t;
	typedef logic [WIN_BITS-1:0]       win_t;
	typedef logic [IN_TDATA_BITS-1:0]  in_tdata_t;
	typedef logic [OUT_TDATA_BITS-1:0] out_tdata_t;

endpackage

// File: hdl/repeated_frame_bit_validator.sv
// ----------------------------------------------------------------------------
// Repeated frame bit validator
// Serial bit window that latches a message once two identical halves arrive and hold a zero followed by a one.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                         notes
// s_axis    in   [0] data_level                                one bit per word
// m_axis    out  [0] matched [1] changed [2] valid_res [58:3]   one word per input
//                message, rest zero
// cfg       in   cfg_wdata = invert_data                       write on cfg_we
//
// One word per cycle sustained while m_axis_tready is high; the window shift and the full-width half
// compare sit between the input register and the result register.
// Reset clears the window, the latched message and the sticky valid flag.
// A held result stalls the input register only when both stages are full.
// ----------------------------------------------------------------------------
`include "repeated_frame_bit_validator_macros.svh"

module repeated_frame_bit_validator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,      // [0] invert_data
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  rfbv_pkg::in_tdata_t         s_axis_tdata,   // [0] data_level
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output rfbv_pkg::out_tdata_t        m_axis_tdata    // [0] matched, [1] changed,
	                                                    // [2] valid_res, [58:3] message
);
	import rfbv_pkg::*;

	logic invert_q;
	logic valid_s1;
	logic bit_s1;
	win_t window_q;
	msg_t latched_q;
	logic seen_q;

	logic                    out_valid_q;
	logic                    out_matched_q;
	logic                    out_changed_q;
	logic                    out_seen_q;
	logic [OUT_MSG_BITS-1:0] out_msg_q;

	logic advance;
	win_t window_nx;
	msg_t older;
	msg_t newer;
	msg_t inv_older;
	logic pair_ok;
	logic zero_then_one;
	logic hit;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// newest bit at index 0, oldest at the top
	assign window_nx = {window_q[WIN_BITS-2:0], bit_s1};
	assign older     = window_nx[WIN_BITS-1:MSG_BITS];
	assign newer     = window_nx[MSG_BITS-1:0];
	assign pair_ok   = (older == newer);

	// a zero followed by a one means older is not of the form 1..10..0
	assign inv_older     = ~older;
	assign zero_then_one = ((inv_older & (inv_older + 1'b1)) != '0);
	assign hit           = pair_ok && zero_then_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b1;
		end else if (cfg_we) begin
			invert_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			bit_s1 <= s_axis_tdata[0] ^ invert_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			latched_q <= '0;
			seen_q    <= 1'b0;
		end else if (advance && valid_s1) begin
			window_q <= window_nx;
			if (hit) begin
				latched_q <= older;
				seen_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_matched_q <= hit;
			out_changed_q <= hit && (older != latched_q);
			out_seen_q    <= seen_q || hit;
			out_msg_q     <= hit ? OUT_MSG_BITS'(older) : OUT_MSG_BITS'(latched_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_BITS'({out_msg_q, out_seen_q, out_changed_q,
		out_matched_q});

	`RFBV_ASSERT(a_changed_needs_match, out_valid_q && out_changed_q |-> out_matched_q)
	`RFBV_ASSERT(a_match_sets_seen, out_valid_q && out_matched_q |-> out_seen_q && seen_q)
	`RFBV_ASSERT(a_match_halves, out_valid_q && out_matched_q |->
		window_q[WIN_BITS-1:MSG_BITS] == latched_q)
	`RFBV_ASSERT_NEXT(a_seen_sticky, seen_q, seen_q)

endmodule
